// ----- rtl/core/clpe_pkg.sv -----
// ----------------------------------------------------------------------------
// clpe_pkg - shared types and codes for the circular list editor
// Command codes, status codes and the control bundle that is broadcast
// from the command decoder to every storage cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package clpe_pkg;

  localparam int WORD_W = 32;
  // Wide enough for any cell index or insert point up to 64 cells
  localparam int PTR_W  = 6;

  localparam logic [2:0] CMD_ADD_FIRST = 3'd0;
  localparam logic [2:0] CMD_ADD_LAST  = 3'd1;
  localparam logic [2:0] CMD_ADD_AT    = 3'd2;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd4;
  localparam logic [2:0] CMD_DEL_AT    = 3'd5;
  localparam logic [2:0] CMD_ROTATE    = 3'd6;
  localparam logic [2:0] CMD_DUMP      = 3'd7;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // What each cell does in the current cycle
  typedef enum logic [2:0] {
    MODE_HOLD   = 3'd0,
    MODE_INSERT = 3'd1,  // cells at or after k move one place back
    MODE_DELETE = 3'd2,  // cells at or after k take the next one
    MODE_ROT_R  = 3'd3,  // last element moves to the front
    MODE_ROT_L  = 3'd4   // front element moves to the last place
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [PTR_W-1:0] k;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/circular_list_positional_edit.sv -----
// ----------------------------------------------------------------------------
// circular_list_positional_edit - ordered circular list in a chain of cells
// Keeps up to CAPACITY signed words in a row of cells and applies one
// edit command per transaction; dump streams the whole list out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | to block  | in_valid / in_ready  | cmd, value, position
//  out     | from block| out_valid / out_ready| element, status, length, last
//
//  Edits (add, delete, rotate): every cell shifts in parallel and the single
//  result lands in the output register at the same edge as the shift.
//  Dump of n elements: the accepting edge only enters the dump state, then
//  one result per cycle while the output slot is free, as the head cell is
//  read once per ring rotation; the list ends rotated back to order.
//  A waiting result stalls input acceptance and the dump stream only.
//  Reset empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_positional_edit #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         cmd,
  input  logic signed [clpe_pkg::WORD_W-1:0] value,
  input  logic [7:0]                         position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [clpe_pkg::WORD_W-1:0] element,
  output logic [1:0]                         status,
  output logic [$clog2(CAPACITY+1)-1:0]      length,
  output logic                               last
);
  import clpe_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  dcnt, dcnt_next;
  ctl_t           ctl;

  logic signed [WORD_W-1:0] q_arr [CAPACITY];
  logic signed [WORD_W-1:0] d_arr [CAPACITY];
  logic signed [WORD_W-1:0] tail;

  logic          slot_free, acc, empty, full;
  logic [7:0]    cnt8, pos_c;
  logic [IW-1:0] tail_ix;
  logic [PTR_W-1:0] cnt_p, pos_p, lastp;

  logic                     emit;
  logic signed [WORD_W-1:0] e_elem;
  logic [1:0]               e_st;
  logic [CW-1:0]            e_len;
  logic                     e_last;
  logic                     e_from_cell;

  // Chain of cells with neighbour links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] lft, rgt;
    if (i == 0) begin : g_first
      assign lft = q_arr[0];
    end else begin : g_mid_l
      assign lft = q_arr[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rgt = q_arr[i];
    end else begin : g_mid_r
      assign rgt = q_arr[i+1];
    end
    clpe_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .value (value),
      .left  (lft),
      .right (rgt),
      .head  (q_arr[0]),
      .tail  (tail),
      .q     (q_arr[i]),
      .d     (d_arr[i])
    );
  end

  // Tail broadcast and position clamp
  assign tail_ix   = IW'(count - CW'(1));
  assign tail      = q_arr[tail_ix];
  assign cnt8      = 8'(count);
  assign pos_c     = (count != '0 && position > cnt8 - 8'd1) ? cnt8 - 8'd1 : position;
  assign cnt_p     = PTR_W'(count);
  assign pos_p     = PTR_W'(pos_c);
  assign lastp     = PTR_W'(count - CW'(1));
  assign empty     = (count == '0);
  assign full      = (count == CW'(CAPACITY));
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;

  // Decode the command or step the dump
  always_comb begin
    state_next  = state;
    count_next  = count;
    dcnt_next   = dcnt;
    ctl.mode    = MODE_HOLD;
    ctl.k       = '0;
    emit        = 1'b0;
    e_st        = ST_DONE;
    e_last      = 1'b1;
    e_from_cell = 1'b0;
    if (state == S_DUMP) begin
      if (slot_free) begin
        emit        = 1'b1;
        e_from_cell = 1'b1;
        e_last      = (dcnt == count - CW'(1));
        ctl.mode    = MODE_ROT_L;
        ctl.k       = lastp;
        dcnt_next   = dcnt + CW'(1);
        if (e_last) state_next = S_IDLE;
      end
    end else if (acc) begin
      emit = 1'b1;
      case (cmd)
        CMD_ADD_FIRST, CMD_ADD_LAST: begin
          if (full) begin
            e_st = ST_FULL;
          end else begin
            ctl.mode   = MODE_INSERT;
            ctl.k      = (cmd == CMD_ADD_LAST) ? cnt_p : '0;
            count_next = count + CW'(1);
          end
        end
        CMD_ADD_AT: begin
          if (empty) begin
            e_st = ST_EMPTY;
          end else if (full) begin
            e_st = ST_FULL;
          end else begin
            // Position zero goes to the front, even on a single element
            ctl.mode   = MODE_INSERT;
            ctl.k      = (pos_p == lastp && pos_p != '0) ? cnt_p : pos_p;
            count_next = count + CW'(1);
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
          if (empty) begin
            e_st = ST_EMPTY;
          end else begin
            ctl.mode   = MODE_DELETE;
            ctl.k      = (cmd == CMD_DEL_FIRST) ? '0 :
                         (cmd == CMD_DEL_LAST) ? lastp : pos_p;
            count_next = count - CW'(1);
          end
        end
        CMD_ROTATE: begin
          if (empty) e_st = ST_EMPTY;
          else ctl.mode = MODE_ROT_R;
        end
        CMD_DUMP: begin
          if (empty) begin
            e_st = ST_EMPTY;
          end else begin
            emit       = 1'b0;
            dcnt_next  = '0;
            state_next = S_DUMP;
          end
        end
        default: e_st = ST_DONE;
      endcase
    end
  end

  // Result word: head during dump, else the new front or zero
  assign e_len  = count_next;
  assign e_elem = e_from_cell ? q_arr[0] :
                  (count_next != '0) ? d_arr[0] : '0;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      dcnt  <= dcnt_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      element <= e_elem;
      status  <= e_st;
      length  <= e_len;
      last    <= e_last;
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_dump_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (dcnt < count))
    else $error("dump index beyond list length");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    acc |=> (count == $past(count) || count == $past(count) + CW'(1) ||
             count + CW'(1) == $past(count)))
    else $error("count moved by more than one");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (length == CW'(CAPACITY)))
    else $error("full status with list not full");

endmodule

`default_nettype wire

// ----- rtl/core/clpe_cell.sv -----
// ----------------------------------------------------------------------------
// clpe_cell - one storage cell of the list chain
// Holds one word and picks its next value from itself, a neighbour, the
// new word, or the head/tail broadcast, as the control bundle directs.
// ----------------------------------------------------------------------------
`default_nettype none

module clpe_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  clpe_pkg::ctl_t                 ctl,
  input  logic signed [clpe_pkg::WORD_W-1:0] value,
  input  logic signed [clpe_pkg::WORD_W-1:0] left,
  input  logic signed [clpe_pkg::WORD_W-1:0] right,
  input  logic signed [clpe_pkg::WORD_W-1:0] head,
  input  logic signed [clpe_pkg::WORD_W-1:0] tail,
  output logic signed [clpe_pkg::WORD_W-1:0] q,
  output logic signed [clpe_pkg::WORD_W-1:0] d
);
  import clpe_pkg::*;

  localparam logic [PTR_W-1:0] MY = PTR_W'(IDX);

  // Select the next word for this cell
  always_comb begin
    case (ctl.mode)
      MODE_INSERT: begin
        if (MY < ctl.k) d = q;
        else if (MY == ctl.k) d = value;
        else d = left;
      end
      MODE_DELETE: d = (MY < ctl.k) ? q : right;
      MODE_ROT_R:  d = (IDX == 0) ? tail : left;
      MODE_ROT_L:  d = (MY == ctl.k) ? head : right;
      default:     d = q;
    endcase
  end

  // Advance the stored word every cycle
  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

`default_nettype wire

// ----- tb/circular_list_positional_edit_test.sv -----
// ----------------------------------------------------------------------------
// circular_list_positional_edit_test - self-checking bench for the list editor
// Drives edit and dump transactions through the input channel and keeps a
// queue-based shadow of the list. Every result on the output channel is
// compared field by field with the oldest one the shadow has predicted.
// Both channels idle at random, and the output is held off for a long spell.
// ----------------------------------------------------------------------------
`default_nettype none

package list_shadow_pkg;

  import clpe_pkg::*;

  localparam int SLOTS = 16;

  typedef struct {
    logic signed [WORD_W-1:0] element;
    logic [1:0]               status;
    logic [4:0]               length;
    logic                     last;
  } list_result_t;

  // Shadow copy of the list plus the results it still owes
  class circular_list_shadow;
    logic signed [WORD_W-1:0] words[$];
    list_result_t             due_results[$];
    int                       mismatches;
    int                       results_seen;
    int                       refused_full;
    int                       refused_empty;
    int                       per_cmd[8];

    function void add_result(logic signed [WORD_W-1:0] e, logic [1:0] s, logic l);
      list_result_t r;
      r.element = e;
      r.status  = s;
      r.length  = 5'(words.size());
      r.last    = l;
      due_results.push_back(r);
    endfunction

    // Apply one accepted transaction and queue what it should produce
    function void apply_command(logic [2:0] c, logic signed [WORD_W-1:0] v,
                                logic [7:0] p);
      int                       n;
      int                       idx;
      logic [1:0]               st;
      logic signed [WORD_W-1:0] moved;
      n   = words.size();
      idx = int'(p);
      st  = ST_DONE;
      per_cmd[c]++;

      // Dump streams every element, or one empty marker
      if (c == CMD_DUMP) begin
        if (n == 0) begin
          refused_empty++;
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) add_result(words[i], ST_DONE, i == n - 1);
        end
        return;
      end

      // Clamp the position to the last element
      if (n > 0 && idx > n - 1) idx = n - 1;

      case (c)
        CMD_ADD_FIRST: begin
          if (n >= SLOTS) st = ST_FULL;
          else words.push_front(v);
        end
        CMD_ADD_LAST: begin
          if (n >= SLOTS) st = ST_FULL;
          else words.push_back(v);
        end
        CMD_ADD_AT: begin
          if (n == 0) st = ST_EMPTY;
          else if (n >= SLOTS) st = ST_FULL;
          else if (idx == 0) words.push_front(v);
          else if (idx == n - 1) words.push_back(v);
          else words.insert(idx, v);
        end
        CMD_DEL_FIRST: begin
          if (n == 0) st = ST_EMPTY;
          else void'(words.pop_front());
        end
        CMD_DEL_LAST: begin
          if (n == 0) st = ST_EMPTY;
          else void'(words.pop_back());
        end
        CMD_DEL_AT: begin
          if (n == 0) st = ST_EMPTY;
          else words.delete(idx);
        end
        default: begin
          // Rotate: last element moves to the front
          if (n == 0) st = ST_EMPTY;
          else begin
            moved = words.pop_back();
            words.push_front(moved);
          end
        end
      endcase

      if (st == ST_FULL) refused_full++;
      if (st == ST_EMPTY) refused_empty++;
      add_result(words.size() > 0 ? words[0] : '0, st, 1'b1);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void match_result(logic signed [WORD_W-1:0] e, logic [1:0] s,
                               logic [4:0] len, logic l);
      list_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result with nothing due: element %0d status %0d length %0d last %0b",
               e, s, len, l);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (e !== want.element) begin
        $error("element: expected %0d, got %0d", want.element, e);
        mismatches++;
      end
      if (s !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, s);
        mismatches++;
      end
      if (len !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, len);
        mismatches++;
      end
      if (l !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, l);
        mismatches++;
      end
    endfunction
  endclass

endpackage

module circular_list_positional_edit_test;

  import clpe_pkg::*;
  import list_shadow_pkg::*;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [2:0]               cmd       = CMD_ADD_FIRST;
  logic signed [WORD_W-1:0] value     = '0;
  logic [7:0]               position  = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] element;
  logic [1:0]               status;
  logic [4:0]               length;
  logic                     last;

  circular_list_shadow shadow;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  hold_left   = 0;
  logic                growing     = 1'b1;

  circular_list_positional_edit #(.CAPACITY(SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .status    (status),
    .length    (length),
    .last      (last)
  );

  always #1 clk = ~clk;

  // Receiver: random back-pressure, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.match_result(element, status, length, last);
  end

  // Offer one command and hold it until accepted
  task automatic send_item(input logic [2:0] c, input logic signed [WORD_W-1:0] v,
                           input logic [7:0] p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (!(in_valid && in_ready));
    shadow.apply_command(c, v, p);
  endtask

  // Stop offering until every owed result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(negedge clk);
  endtask

  // Random commands that swing the list between empty and full
  task automatic random_run(input int items);
    int         n;
    int         r;
    logic [2:0] c;
    logic [7:0] p;
    for (int k = 0; k < items; k++) begin
      n = shadow.words.size();
      if (n == SLOTS && $urandom_range(3) == 0) growing = 1'b0;
      if (n == 0 && $urandom_range(1) == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 8) c = CMD_DUMP;
      else if (r < 14) c = CMD_ROTATE;
      else if ((r < 70) == growing) begin
        case ($urandom_range(2))
          0:       c = CMD_ADD_FIRST;
          1:       c = CMD_ADD_LAST;
          default: c = CMD_ADD_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       c = CMD_DEL_FIRST;
          1:       c = CMD_DEL_LAST;
          default: c = CMD_DEL_AT;
        endcase
      end
      // Mostly positions near the list, sometimes anywhere in the field
      p = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(n + 1));
      send_item(c, $urandom, p);
    end
  endtask

  initial begin
    shadow = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 26;
    rx_idle_pct = 80;

    // Empty list: everything but plain adds is refused
    send_item(CMD_ADD_AT,    32'sd5, 8'd0);
    send_item(CMD_DEL_FIRST, 32'sd0, 8'd0);
    send_item(CMD_DEL_LAST,  32'sd0, 8'd0);
    send_item(CMD_DEL_AT,    32'sd0, 8'd255);
    send_item(CMD_ROTATE,    32'sd0, 8'd0);
    send_item(CMD_DUMP,      32'sd0, 8'd0);
    // Single element: rotate, add at front, clamped delete of the last
    send_item(CMD_ADD_FIRST, 32'sh8000_0000, 8'd0);
    send_item(CMD_ROTATE,    32'sd0, 8'd0);
    send_item(CMD_ADD_AT,    32'sh7fff_ffff, 8'd255);
    send_item(CMD_DEL_AT,    32'sd0, 8'd200);
    // Build up, insert in the middle and at the end
    send_item(CMD_ADD_LAST,  32'sd0, 8'd0);
    send_item(CMD_ADD_LAST,  -32'sd1, 8'd0);
    send_item(CMD_ADD_AT,    32'sh5555_5555, 8'd1);
    send_item(CMD_ADD_AT,    32'shaaaa_aaaa, 8'd3);
    send_item(CMD_DUMP,      32'sd0, 8'd0);
    send_item(CMD_ROTATE,    32'sd0, 8'd0);
    send_item(CMD_DEL_AT,    32'sd0, 8'd2);
    send_item(CMD_DEL_FIRST, 32'sd0, 8'd0);
    send_item(CMD_DEL_LAST,  32'sd0, 8'd0);
    send_item(CMD_DUMP,      32'sd0, 8'd0);
    // Shrink to one, then delete at on the single element
    send_item(CMD_DEL_AT,    32'sd0, 8'd0);
    send_item(CMD_DEL_AT,    32'sd0, 8'd255);
    send_item(CMD_DUMP,      32'sd0, 8'd0);

    random_run(105);
    drain_results();

    tx_idle_pct = 80;
    rx_idle_pct = 26;
    random_run(105);
    drain_results();

    // No idling; hold the output off so the block backs up its input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 150;
    random_run(100);

    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d transactions: adds %0d/%0d/%0d, deletes %0d/%0d/%0d, rotates %0d, dumps %0d",
             shadow.per_cmd[CMD_ADD_FIRST] + shadow.per_cmd[CMD_ADD_LAST]
               + shadow.per_cmd[CMD_ADD_AT] + shadow.per_cmd[CMD_DEL_FIRST]
               + shadow.per_cmd[CMD_DEL_LAST] + shadow.per_cmd[CMD_DEL_AT]
               + shadow.per_cmd[CMD_ROTATE] + shadow.per_cmd[CMD_DUMP],
             shadow.per_cmd[CMD_ADD_FIRST], shadow.per_cmd[CMD_ADD_LAST],
             shadow.per_cmd[CMD_ADD_AT], shadow.per_cmd[CMD_DEL_FIRST],
             shadow.per_cmd[CMD_DEL_LAST], shadow.per_cmd[CMD_DEL_AT],
             shadow.per_cmd[CMD_ROTATE], shadow.per_cmd[CMD_DUMP]);
    $display("checked %0d results; %0d refused on a full store, %0d on an empty list",
             shadow.results_seen, shadow.refused_full, shadow.refused_empty);
    if (shadow.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/clpe_pkg.sv
rtl/core/clpe_cell.sv
rtl/core/circular_list_positional_edit.sv
tb/circular_list_positional_edit_test.sv
